// ----- hdl/lru_timestamp_cache_tags_top_assert.svh -----
// assertion macros for the lru timestamp cache tag store
// used by lru_timestamp_cache_tags_top; expects clk and rst_n in scope
`ifndef LRU_TIMESTAMP_CACHE_TAGS_TOP_ASSERT_SVH
`define LRU_TIMESTAMP_CACHE_TAGS_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define LRUT_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define LRUT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lrut_pkg.sv -----
// shared types and codes of the lru timestamp cache tag store
// no dependencies
package lrut_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ENTRY_ID_W = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned PRESENT_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic                 enable;
    logic [PRESENT_W-1:0] present;
  } cfg_t;

endpackage

// ----- hdl/lrut_entry_ram.sv -----
// entry memory of the tag store with separate read and write ports: one write and one registered read per cycle
// no dependencies
module lrut_entry_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned WIDTH = 80
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/lrut_ctrl.sv -----
// lookup sequencer: scans the entry memory for a tag hit and the lru victim, then writes back
// depends on lrut_pkg and lrut_entry_ram
module lrut_ctrl #(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned ID_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrut_pkg::cfg_t                      cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic [lrut_pkg::ENTRY_ID_W-1:0]     in_entry_id,
  input  logic                                in_fill_ok,
  input  logic [lrut_pkg::COLOR_W-1:0]        in_fill_color_key,
  output logic                                out_valid,
  output logic [lrut_pkg::STATUS_W-1:0]       out_status,
  output logic [lrut_pkg::SLOT_OUT_W-1:0]     out_slot_index,
  output logic [lrut_pkg::COLOR_W-1:0]        out_color_key,
  output logic [lrut_pkg::CNT_W-1:0]          out_hit_count,
  output logic [lrut_pkg::CNT_W-1:0]          out_miss_count
);

  localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = lrut_pkg::COLOR_W;
  localparam int unsigned TW   = lrut_pkg::TIME_W;
  localparam int unsigned EW   = ID_BITS + CW + TW;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic                ok_r, ok_nxt;
  logic [CW-1:0]       nkey_r, nkey_nxt;
  logic [TW-1:0]       clock_r, clock_nxt;
  logic [SW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [SW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [SW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [CW-1:0]       hit_color_r, hit_color_nxt;
  logic                found_r, found_nxt;
  logic [SW-1:0]       best_idx_r, best_idx_nxt;
  logic [TW-1:0]       best_time_r, best_time_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [SLOTS-1:0]    tw_r, tw_nxt;
  logic [lrut_pkg::CNT_W-1:0] hits_r, hits_nxt;
  logic [lrut_pkg::CNT_W-1:0] misses_r, misses_nxt;

  logic                            ov_r, ov_nxt;
  logic [lrut_pkg::STATUS_W-1:0]   ost_r, ost_nxt;
  logic [lrut_pkg::SLOT_OUT_W-1:0] oslot_r, oslot_nxt;
  logic [CW-1:0]                   okey_r, okey_nxt;

  logic                rd_en;
  logic [EW-1:0]       rd_data;
  logic                wr_en;
  logic [SW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;

  logic [ID_BITS+31:0] id_ext;
  logic [ID_BITS-1:0]  id_in;
  logic [ID_BITS-1:0]  e_key;
  logic [CW-1:0]       e_color;
  logic [TW-1:0]       e_time;
  logic                chk_pres;
  logic                is_hit;
  logic                take;

  lrut_entry_ram #(
    .DEPTH (SLOTS),
    .AW    (SW),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // slots at index eight or more have no present bit
  function automatic logic slot_pres(input logic [SW-1:0] idx,
                                     input logic [lrut_pkg::PRESENT_W-1:0] pres);
    logic [SW+2:0] ix;
    ix = {3'b000, idx};
    return (ix < (SW + 3)'(8)) && pres[ix[2:0]];
  endfunction

  function automatic logic [lrut_pkg::SLOT_OUT_W-1:0] slot_out(input logic [SW-1:0] idx);
    logic [SW+2:0] ix;
    ix = {3'b000, idx};
    return ix[2:0];
  endfunction

  assign id_ext = {{ID_BITS{1'b0}}, in_entry_id};
  assign id_in  = id_ext[ID_BITS-1:0];

  assign e_key    = rd_data[EW-1 -: ID_BITS];
  assign e_color  = rd_data[TW +: CW];
  // a slot whose time was never written reads as zero
  assign e_time   = tw_r[chk_idx_r] ? rd_data[TW-1:0] : '0;
  assign chk_pres = slot_pres(chk_idx_r, cfg.present);
  assign is_hit   = chk_vld_r && chk_pres && valid_r[chk_idx_r] && (e_key == id_r);
  assign take     = chk_vld_r && chk_pres && (!found_r || (e_time < best_time_r));

  assign rd_en = (state_r == S_SCAN);
  assign busy  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    ok_nxt        = ok_r;
    nkey_nxt      = nkey_r;
    clock_nxt     = clock_r;
    rd_idx_nxt    = rd_idx_r;
    chk_vld_nxt   = (state_r == S_SCAN);
    chk_idx_nxt   = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_color_nxt = hit_color_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    valid_nxt     = valid_r;
    tw_nxt        = tw_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    ov_nxt        = 1'b0;
    ost_nxt       = ost_r;
    oslot_nxt     = oslot_r;
    okey_nxt      = okey_r;
    wr_en         = 1'b0;
    wr_addr       = best_idx_r;
    wr_data       = {id_r, nkey_r, clock_r};

    // first hit in index order wins
    if (is_hit && !hit_r) begin
      hit_nxt       = 1'b1;
      hit_idx_nxt   = chk_idx_r;
      hit_color_nxt = e_color;
    end
    if (take) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = chk_idx_r;
      best_time_nxt = e_time;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!cfg.enable || (id_in == '0)) begin
            ov_nxt    = 1'b1;
            ost_nxt   = lrut_pkg::ST_REFUSED;
            oslot_nxt = '0;
            okey_nxt  = '0;
          end else begin
            id_nxt     = id_in;
            ok_nxt     = in_fill_ok;
            nkey_nxt   = in_fill_color_key;
            clock_nxt  = clock_r + 1'b1;
            rd_idx_nxt = '0;
            hit_nxt    = 1'b0;
            found_nxt  = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      S_LAST: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        priority if (hit_r) begin
          wr_en              = 1'b1;
          wr_addr            = hit_idx_r;
          wr_data            = {id_r, hit_color_r, clock_r};
          tw_nxt[hit_idx_r]  = 1'b1;
          hits_nxt           = hits_r + 1'b1;
          ost_nxt            = lrut_pkg::ST_HIT;
          oslot_nxt          = slot_out(hit_idx_r);
          okey_nxt           = hit_color_r;
        end else if (!found_r) begin
          ost_nxt   = lrut_pkg::ST_REFUSED;
          oslot_nxt = '0;
          okey_nxt  = '0;
        end else if (!ok_r) begin
          valid_nxt[best_idx_r] = 1'b0;
          ost_nxt   = lrut_pkg::ST_FAILED;
          oslot_nxt = slot_out(best_idx_r);
          okey_nxt  = '0;
        end else begin
          wr_en                 = 1'b1;
          valid_nxt[best_idx_r] = 1'b1;
          tw_nxt[best_idx_r]    = 1'b1;
          misses_nxt            = misses_r + 1'b1;
          ost_nxt               = lrut_pkg::ST_FILLED;
          oslot_nxt             = slot_out(best_idx_r);
          okey_nxt              = nkey_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clock_r   <= '0;
      chk_vld_r <= 1'b0;
      valid_r   <= '0;
      tw_r      <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clock_r   <= clock_nxt;
      chk_vld_r <= chk_vld_nxt;
      valid_r   <= valid_nxt;
      tw_r      <= tw_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    ok_r        <= ok_nxt;
    nkey_r      <= nkey_nxt;
    rd_idx_r    <= rd_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_color_r <= hit_color_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
    ost_r       <= ost_nxt;
    oslot_r     <= oslot_nxt;
    okey_r      <= okey_nxt;
  end

  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_slot_index = oslot_r;
  assign out_color_key  = okey_r;
  assign out_hit_count  = hits_r;
  assign out_miss_count = misses_r;

endmodule

// ----- hdl/lru_timestamp_cache_tags_top.sv -----
// top level of the lru timestamp cache tag store: configuration registers and sequencer
// depends on lrut_pkg, lrut_ctrl and lru_timestamp_cache_tags_top_assert.svh
//
// usage:
//   requests: drive in_entry_id, in_fill_ok and in_fill_color_key with start; a
//   transaction is taken at a clock edge with start high and busy low.
//   results: one per request, shown for a single cycle with out_valid high. the
//   receiver cannot stall, so it must sample whenever out_valid is high.
//   configuration: cfg_index/cfg_wdata with cfg_valid; cfg_ready is always high.
//   index 0 is the enable bit, index 1 the slot present mask. write only while idle.
// request handling:
//   a refused request (disabled or empty id) shows its result in the cycle right
//   after the accept and the block is ready again right away.
//   a lookup reads the entry memory one slot per cycle in the scan state and then
//   passes the last and fin states; its result shows as it returns to idle, while a
//   hit or a fill writes its slot back; busy drops then, so the block takes no new
//   request before the result of the previous one has shown.
// reset: rst_n low clears valid bits, last-use times, use clock and both counters;
//   the block comes up disabled with all eight slots present. no clearing pass.
module lru_timestamp_cache_tags_top #(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned ID_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [lrut_pkg::ENTRY_ID_W-1:0]     in_entry_id,
  input  logic                                in_fill_ok,
  input  logic [lrut_pkg::COLOR_W-1:0]        in_fill_color_key,
  output logic                                out_valid,
  output logic [lrut_pkg::STATUS_W-1:0]       out_status,
  output logic [lrut_pkg::SLOT_OUT_W-1:0]     out_slot_index,
  output logic [lrut_pkg::COLOR_W-1:0]        out_color_key,
  output logic [lrut_pkg::CNT_W-1:0]          out_hit_count,
  output logic [lrut_pkg::CNT_W-1:0]          out_miss_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrut_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrut_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lrut_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == lrut_pkg::REG_ENABLE) begin
        cfg_nxt.enable = cfg_wdata[0];
      end else if (cfg_index == lrut_pkg::REG_PRESENT) begin
        cfg_nxt.present = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable  <= 1'b0;
      cfg_r.present <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lrut_ctrl #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .start             (start),
    .busy              (busy),
    .in_entry_id       (in_entry_id),
    .in_fill_ok        (in_fill_ok),
    .in_fill_color_key (in_fill_color_key),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_color_key     (out_color_key),
    .out_hit_count     (out_hit_count),
    .out_miss_count    (out_miss_count)
  );

`include "lru_timestamp_cache_tags_top_assert.svh"

  // a disabled block answers a request on the next cycle with a refusal
  `LRUT_ASSERT_NEXT(a_disabled_refuses, start && !busy && !cfg_r.enable, out_valid && (out_status == lrut_pkg::ST_REFUSED), "disabled request not refused")
  // a hit moves the hit counter by exactly one
  `LRUT_ASSERT_SAME(a_hit_counts, out_valid && (out_status == lrut_pkg::ST_HIT), out_hit_count == ($past(out_hit_count) + 32'd1), "hit counter out of step")
  // a filled miss moves the miss counter by exactly one
  `LRUT_ASSERT_SAME(a_fill_counts, out_valid && (out_status == lrut_pkg::ST_FILLED), out_miss_count == ($past(out_miss_count) + 32'd1), "miss counter out of step")
  // every result follows an accepted request or the end of a lookup
  `LRUT_ASSERT_SAME(a_result_source, out_valid, $past(busy) || $past(start), "result without a request")

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the lru timestamp cache tag store
// depends on lrut_pkg and lru_timestamp_cache_tags_top; predicts every result in line
`timescale 1ns / 1ps

module testbench;
  import lrut_pkg::*;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned ID_BITS = 32;
  localparam logic [ENTRY_ID_W-1:0] ID_MASK = (ID_BITS >= ENTRY_ID_W) ? '1 :
                                              ENTRY_ID_W'((64'd1 << ID_BITS) - 1);
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int unsigned LIMIT   = 200000;
  localparam int unsigned SETTLE  = SLOTS + 8;

  typedef struct {
    logic [ENTRY_ID_W-1:0] id;
    logic                  ok;
    logic [COLOR_W-1:0]    key;
    int unsigned           gap;
  } lookup_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COLOR_W-1:0]    color;
    logic [CNT_W-1:0]      hits;
    logic [CNT_W-1:0]      misses;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ENTRY_ID_W-1:0] in_entry_id = '0;
  logic in_fill_ok = 1'b0;
  logic [COLOR_W-1:0] in_fill_color_key = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [COLOR_W-1:0] out_color_key;
  logic [CNT_W-1:0] out_hit_count;
  logic [CNT_W-1:0] out_miss_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lookup_t  lookup_q[$];
  outcome_t outcome_q[$];
  lookup_t  cur_lookup;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // shadow of the tag store
  logic                  sh_enable = 1'b0;
  logic [PRESENT_W-1:0]  sh_present = '1;
  logic                  sh_valid[SLOTS];
  logic [ID_BITS-1:0]    sh_tag[SLOTS];
  logic [COLOR_W-1:0]    sh_color[SLOTS];
  logic [TIME_W-1:0]     sh_time[SLOTS];
  logic [TIME_W-1:0]     sh_clock = '0;
  logic [CNT_W-1:0]      sh_hits = '0;
  logic [CNT_W-1:0]      sh_misses = '0;

  lru_timestamp_cache_tags_top #(
    .SLOTS  (SLOTS),
    .ID_BITS(ID_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_entry_id      (in_entry_id),
    .in_fill_ok       (in_fill_ok),
    .in_fill_color_key(in_fill_color_key),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_color_key    (out_color_key),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic slot_usable(int unsigned s);
    return (s < PRESENT_W) && sh_present[s];
  endfunction

  // one lookup against the shadow store, updating it
  function automatic outcome_t lookup_tags(lookup_t r);
    outcome_t res;
    logic [ID_BITS-1:0] id;
    logic hit;
    logic found;
    int unsigned victim;
    id = ID_BITS'(r.id & ID_MASK);
    res.status = ST_REFUSED;
    res.slot = '0;
    res.color = '0;
    hit = 1'b0;
    found = 1'b0;
    victim = 0;
    if (sh_enable && id != '0) begin
      sh_clock = sh_clock + 1'b1;
      for (int unsigned s = 0; s < SLOTS; s++) begin
        if (!hit && slot_usable(s) && sh_valid[s] && sh_tag[s] == id) begin
          hit = 1'b1;
          sh_time[s] = sh_clock;
          sh_hits = sh_hits + 1'b1;
          res.status = ST_HIT;
          res.slot = SLOT_OUT_W'(s);
          res.color = sh_color[s];
        end
      end
      if (!hit) begin
        // least recent present slot, lowest index wins a tie
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (slot_usable(s) && (!found || sh_time[s] < sh_time[victim])) begin
            victim = s;
            found = 1'b1;
          end
        end
        if (found && !r.ok) begin
          sh_valid[victim] = 1'b0;
          res.status = ST_FAILED;
          res.slot = SLOT_OUT_W'(victim);
        end else if (found) begin
          sh_misses = sh_misses + 1'b1;
          sh_valid[victim] = 1'b1;
          sh_tag[victim] = id;
          sh_color[victim] = r.key;
          sh_time[victim] = sh_clock;
          res.status = ST_FILLED;
          res.slot = SLOT_OUT_W'(victim);
          res.color = r.key;
        end
      end
    end
    res.hits = sh_hits;
    res.misses = sh_misses;
    return res;
  endfunction

  // request driver: predicts each transaction at the edge that takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(lookup_tags(cur_lookup));
      end
      if (!start || !busy) begin
        if (lookup_q.size() > 0 && lookup_q[0].gap == 0) begin
          cur_lookup = lookup_q.pop_front();
          start <= 1'b1;
          in_entry_id <= cur_lookup.id;
          in_fill_ok <= cur_lookup.ok;
          in_fill_color_key <= cur_lookup.key;
        end else begin
          if (lookup_q.size() > 0) begin
            lookup_q[0].gap = lookup_q[0].gap - 1;
          end
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("unexpected result: status %0d slot %0d color %h", out_status,
                   out_slot_index, out_color_key);
        end
      end else begin
        exp_res = outcome_q.pop_front();
        if (out_status !== exp_res.status || out_slot_index !== exp_res.slot ||
            out_color_key !== exp_res.color || out_hit_count !== exp_res.hits ||
            out_miss_count !== exp_res.misses) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: expected status %0d slot %0d color %h hits %0d misses %0d",
                     exp_res.status, exp_res.slot, exp_res.color, exp_res.hits,
                     exp_res.misses);
            $display("          got      status %0d slot %0d color %h hits %0d misses %0d",
                     out_status, out_slot_index, out_color_key, out_hit_count,
                     out_miss_count);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic queue_lookup(logic [ENTRY_ID_W-1:0] id, logic ok, logic [COLOR_W-1:0] key);
    lookup_t r;
    r.id = id;
    r.ok = ok;
    r.key = key;
    r.gap = $urandom_range(0, 9);
    lookup_q.push_back(r);
  endtask

  task automatic drain();
    while (lookup_q.size() != 0 || start || outcome_q.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // caller lowers cfg_valid after the last write of a group
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:  sh_enable = val[0];
      REG_PRESENT: sh_present = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic en, logic [PRESENT_W-1:0] mask);
    drain();
    write_reg(REG_ENABLE, {7'($urandom), en});
    write_reg(REG_PRESENT, mask);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned n, int unsigned pool_n);
    logic [ENTRY_ID_W-1:0] pool[$];
    logic [ENTRY_ID_W-1:0] v;
    lookup_t r;
    int unsigned sel;
    logic no_gaps;
    for (int unsigned k = 0; k < pool_n; k++) begin
      do v = $urandom; while (v == '0);
      pool.push_back(v);
    end
    no_gaps = ($urandom_range(0, 2) == 0);
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) r.id = '0;
      else if (sel < 12) r.id = $urandom;
      else r.id = pool[$urandom_range(0, pool_n - 1)];
      r.ok = ($urandom_range(0, 9) != 0);
      r.key = COLOR_W'($urandom);
      if (no_gaps || $urandom_range(0, 3) == 0) r.gap = 0;
      else r.gap = $urandom_range(0, 9);
      lookup_q.push_back(r);
    end
  endtask

  initial begin
    for (int unsigned s = 0; s < SLOTS; s++) begin
      sh_valid[s] = 1'b0;
      sh_time[s] = '0;
      sh_tag[s] = '0;
      sh_color[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset
    queue_lookup(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    queue_lookup(32'h0, 1'b1, 16'h1234);
    drain();
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h5A);
    cfg_valid <= 1'b0;
    set_config(1'b1, 8'hFF);

    queue_lookup(32'h0, 1'b1, 16'hFFFF);
    queue_lookup(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    queue_lookup(32'h1, 1'b1, 16'h0000);
    queue_lookup(32'hFFFF_FFFF, 1'b0, 16'h0F0F);
    // failed fill leaves the victim invalid, then a good fill takes it
    queue_lookup(32'h8000_0000, 1'b0, 16'h1234);
    queue_lookup(32'h8000_0000, 1'b1, 16'h8000);
    // fill the rest, then evict the oldest
    for (int unsigned k = 2; k < 8; k++) begin
      queue_lookup(k, 1'b1, 16'($urandom));
    end
    queue_lookup(32'h1, 1'b1, 16'h00FF);
    queue_lookup(32'hFFFF_FFFF, 1'b1, 16'hAAAA);

    // no slot present: clock ticks, request refused
    set_config(1'b1, 8'h00);
    queue_lookup(32'h5, 1'b1, 16'h5555);
    set_config(1'b1, 8'h80);
    queue_lookup(32'hFFFF_FFFF, 1'b1, 16'hC0DE);
    queue_lookup(32'h0000_DEAD, 1'b1, 16'hBEEF);
    set_config(1'b0, 8'hFF);
    queue_lookup(32'h7, 1'b1, 16'h7777);

    set_config(1'b1, 8'hFF);
    run_random(200, 10);
    set_config(1'b1, PRESENT_W'($urandom_range(1, 254)));
    run_random(120, 6);
    set_config(1'b1, 8'h01);
    run_random(60, 3);
    set_config(1'b1, 8'h80);
    run_random(60, 3);
    set_config(1'b0, PRESENT_W'($urandom_range(0, 255)));
    run_random(30, 4);
    set_config(1'b1, 8'h00);
    run_random(30, 4);
    set_config(1'b1, PRESENT_W'($urandom_range(1, 254)));
    run_random(120, 12);
    set_config(1'b1, 8'hFF);
    run_random(180, 14);
    drain();

    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lrut_pkg.sv
hdl/lrut_entry_ram.sv
hdl/lrut_ctrl.sv
hdl/lru_timestamp_cache_tags_top.sv
tb/sv/testbench.sv
